FILE: hw/rtl/base10000_numeric_to_scaled_int128_macros.svh
// assertion macros shared by the base-10000 decimal converter
// no dependencies; included by the modules that carry assertions
`ifndef BASE10000_NUMERIC_TO_SCALED_INT128_MACROS_SVH
`define BASE10000_NUMERIC_TO_SCALED_INT128_MACROS_SVH
`ifndef SYNTHESIS
`define BNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define BNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define BNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/bnc_pkg.sv
// shared types and constants of the base-10000 decimal converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bnc_pkg;
  localparam int unsigned MaxDigits = 128;
  localparam int unsigned CntW      = 8;
  localparam int unsigned ScaleW    = 6;
  localparam int unsigned ValW      = 128;
  localparam int unsigned KW        = 7;

  localparam logic [1:0] HdrSpecial = 2'b11;
  localparam logic [1:0] HdrShort   = 2'b10;
  localparam logic [1:0] HdrLongNeg = 2'b01;
  localparam logic [1:0] HdrLongPos = 2'b00;

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhWeight = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;

  localparam int signed MaxDivPow = 38;

  // one queued conversion job
  typedef struct packed {
    logic            zero;
    logic            mul;
    logic            neg;
    logic [KW-1:0]   k;
    logic [ValW-1:0] v;
  } job_t;
endpackage
`default_nettype wire

FILE: hw/rtl/bnc_ifs.sv
// handshake channel interfaces of the converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface bnc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        last;
  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

interface bnc_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] value_low;
  logic signed [63:0] value_high;
  modport source (output valid, output value_low, output value_high, input ready);
  modport sink (input valid, input value_low, input value_high, output ready);
endinterface

interface bnc_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] scale;
  modport source (output valid, output scale, input ready);
  modport sink (input valid, input scale, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/base10000_numeric_to_scaled_int128.sv
// front: a digit word takes two times-100 steps, on acceptance and in the digit state
// back part: scaling up by 10^k repeats a times-ten step; dividing first builds the
// divisor 10^k the same way, then runs a one-bit restoring divider over 128 bits
// a two-entry job queue lets the front read the next number while the back works
// reset (rst_n low, synchronous): number state and queue cleared, scale register = 2
`timescale 1ns / 1ps
`default_nettype none
module base10000_numeric_to_scaled_int128 (
  input wire logic clk,
  input wire logic rst_n,
  bnc_in_if.sink   in_ch,
  bnc_out_if.source out_ch,
  bnc_cfg_if.sink  cfg_ch
);
  import bnc_pkg::*;

  logic [ScaleW-1:0] scale_r;
  logic              q_full, q_push, q_valid, q_pop;
  job_t              push_job, head_job;
  logic [ValW-1:0]   res;

  // configuration register, always ready
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= ScaleW'(2);
    end else if (cfg_ch.valid) begin
      scale_r <= cfg_ch.scale;
    end
  end

  // front: classifies words and accumulates digits
  bnc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .scale    (scale_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_ch.word),
    .in_last  (in_ch.last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // job queue between the two halves
  bnc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_job),
    .pop      (q_pop)
  );

  // back: scaling, division, sign and result item register
  bnc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (res)
  );

  assign out_ch.value_low  = res[63:0];
  assign out_ch.value_high = signed'(res[127:64]);
endmodule
`default_nettype wire

FILE: hw/rtl/bnc_front.sv
// front part: header decode, horner accumulation, job build
// depends on bnc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bnc_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [bnc_pkg::ScaleW-1:0] scale,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [15:0]                in_word,
  input  wire logic                       in_last,
  input  wire logic                       q_full,
  output logic                            q_push,
  output bnc_pkg::job_t                   q_job
);
  import bnc_pkg::*;

  typedef enum logic [1:0] {
    F_ACC = 2'b01,
    F_DIG = 2'b10
  } fstate_t;

  fstate_t          st_r, st_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt, spec_r, spec_nxt;
  logic [15:0]      wgt_r, wgt_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [ValW-1:0]  acc_r, acc_nxt;
  logic [15:0]      d_r, d_nxt;
  logic             last_r, last_nxt;
  logic [ValW-1:0]  acc_x100, acc_dig;
  logic             acc_take, is_digit;

  logic             b_neg, b_spec;
  logic [15:0]      b_wgt;
  logic [CntW-1:0]  b_cnt;
  logic [ValW-1:0]  b_acc;
  logic signed [19:0] e_s, e_neg;

  // times one hundred as three shifted terms
  assign acc_x100 = (acc_r << 6) + (acc_r << 5) + (acc_r << 2);
  assign acc_dig  = acc_x100 + {{(ValW-16){d_r[15]}}, d_r};

  assign acc_take = in_valid && in_ready;
  assign in_ready = (st_r == F_ACC) && !q_full;
  assign is_digit = (phase_r == PhDigits) && !spec_r && (cnt_r < CntW'(MaxDigits));

  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    spec_nxt  = spec_r;
    wgt_nxt   = wgt_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    last_nxt  = last_r;
    q_push    = 1'b0;
    b_neg     = neg_r;
    b_spec    = spec_r;
    b_wgt     = wgt_r;
    b_cnt     = cnt_r;
    b_acc     = acc_r;
    case (st_r)
      F_ACC: begin
        if (acc_take) begin
          if (phase_r == PhWeight) begin
            wgt_nxt   = in_word;
            phase_nxt = PhDigits;
            b_wgt     = in_word;
          end else if (phase_r == PhDigits) begin
            if (is_digit) begin
              acc_nxt  = acc_x100;
              d_nxt    = in_word;
              last_nxt = in_last;
              st_nxt   = F_DIG;
            end
          end else begin
            neg_nxt  = 1'b0;
            spec_nxt = 1'b0;
            wgt_nxt  = '0;
            cnt_nxt  = '0;
            acc_nxt  = '0;
            case (in_word[15:14])
              HdrSpecial: begin
                spec_nxt  = 1'b1;
                phase_nxt = PhDigits;
              end
              HdrShort: begin
                neg_nxt   = in_word[13];
                wgt_nxt   = {{10{in_word[6]}}, in_word[5:0]};
                phase_nxt = PhDigits;
              end
              default: begin
                neg_nxt   = (in_word[15:14] == HdrLongNeg);
                phase_nxt = PhWeight;
              end
            endcase
            b_cnt = '0;
          end
          if (in_last && !(phase_r == PhDigits && is_digit)) begin
            q_push = 1'b1;
          end
        end
      end
      F_DIG: begin
        acc_nxt = acc_dig;
        cnt_nxt = cnt_r + 1'b1;
        b_acc   = acc_dig;
        b_cnt   = cnt_r + 1'b1;
        st_nxt  = F_ACC;
        q_push  = last_r;
      end
      default: st_nxt = F_ACC;
    endcase
    // number done: start over
    if (q_push) begin
      phase_nxt = PhHeader;
      neg_nxt   = 1'b0;
      spec_nxt  = 1'b0;
      wgt_nxt   = '0;
      cnt_nxt   = '0;
      acc_nxt   = '0;
    end
  end

  // exponent of ten left after the digits are placed
  assign e_s   = ((20'(signed'(b_wgt)) - $signed({12'd0, b_cnt}) + 20'sd1) <<< 2)
                 + $signed({14'd0, scale});
  assign e_neg = -e_s;

  always_comb begin
    q_job.neg  = b_neg;
    q_job.v    = b_acc;
    q_job.mul  = (e_s >= 20'sd0);
    q_job.k    = q_job.mul ? e_s[KW-1:0] : e_neg[KW-1:0];
    q_job.zero = b_spec || (b_cnt == '0) || (e_s >= 20'sd128)
                 || (e_neg > 20'(MaxDivPow));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_ACC;
      phase_r <= PhHeader;
      neg_r   <= 1'b0;
      spec_r  <= 1'b0;
      wgt_r   <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      spec_r  <= spec_nxt;
      wgt_r   <= wgt_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/bnc_queue.sv
// two-entry job queue between front and back
// depends on bnc_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "base10000_numeric_to_scaled_int128_macros.svh"
module bnc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  bnc_pkg::job_t      push_job,
  output logic               full,
  output logic               valid,
  output bnc_pkg::job_t      head,
  input  wire logic          pop
);
  import bnc_pkg::*;

  job_t       mem [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `BNC_ASSERT_IMP(a_no_overrun, clk, rst_n, full, !push || pop)
  `BNC_ASSERT_IMP(a_no_underrun, clk, rst_n, pop, valid)
  `BNC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
endmodule
`default_nettype wire

FILE: hw/rtl/bnc_back.sv
// back part: power-of-ten scaling, restoring division, sign, result register
// depends on bnc_pkg and the macros header
`timescale 1ns / 1ps
`default_nettype none
`include "base10000_numeric_to_scaled_int128_macros.svh"
module bnc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  bnc_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [127:0]       out_value
);
  import bnc_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_DEN  = 6'b000100,
    B_DIV  = 6'b001000,
    B_FIX  = 6'b010000,
    B_DONE = 6'b100000
  } bstate_t;

  bstate_t         st_r, st_nxt;
  logic [ValW-1:0] v_r, v_nxt, den_r, den_nxt, rem_r, rem_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            sgn_r, sgn_nxt;
  logic            ov_r, ov_nxt;
  logic [ValW-1:0] ores_r, ores_nxt;
  logic [ValW-1:0] rem_s, rem_sub, v_abs;
  logic            ge;

  assign rem_s   = {rem_r[ValW-2:0], v_r[ValW-1]};
  assign rem_sub = rem_s - den_r;
  assign ge      = (rem_s >= den_r);
  assign v_abs   = q_job.v[ValW-1] ? -q_job.v : q_job.v;

  assign q_pop     = (st_r == B_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_value = ores_r;

  always_comb begin
    st_nxt   = st_r;
    v_nxt    = v_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    k_nxt    = k_r;
    sgn_nxt  = sgn_r;
    ov_nxt   = ov_r && !out_ready;
    ores_nxt = ores_r;
    case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          k_nxt = q_job.k;
          if (q_job.zero) begin
            v_nxt  = '0;
            st_nxt = B_DONE;
          end else if (q_job.mul) begin
            v_nxt   = q_job.v;
            sgn_nxt = q_job.neg;
            st_nxt  = B_MUL;
          end else begin
            v_nxt   = v_abs;
            sgn_nxt = q_job.neg ^ q_job.v[ValW-1];
            den_nxt = ValW'(1);
            st_nxt  = B_DEN;
          end
        end
      end
      B_MUL: begin
        if (k_r == '0) begin
          st_nxt = B_FIX;
        end else begin
          v_nxt = (v_r << 3) + (v_r << 1);
          k_nxt = k_r - 1'b1;
        end
      end
      B_DEN: begin
        if (k_r == '0) begin
          rem_nxt = '0;
          k_nxt   = KW'(ValW - 1);
          st_nxt  = B_DIV;
        end else begin
          den_nxt = (den_r << 3) + (den_r << 1);
          k_nxt   = k_r - 1'b1;
        end
      end
      B_DIV: begin
        rem_nxt = ge ? rem_sub : rem_s;
        v_nxt   = {v_r[ValW-2:0], ge};
        k_nxt   = k_r - 1'b1;
        if (k_r == '0) begin
          st_nxt = B_FIX;
        end
      end
      B_FIX: begin
        v_nxt  = sgn_r ? -v_r : v_r;
        st_nxt = B_DONE;
      end
      B_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          ores_nxt = v_r;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    k_r    <= k_nxt;
    sgn_r  <= sgn_nxt;
    ores_r <= ores_nxt;
  end

  `BNC_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == B_IDLE)
  `BNC_ASSERT_IMP(a_div_den, clk, rst_n, st_r == B_DIV, den_r != '0)
  `BNC_ASSERT_NXT(a_done_loads, clk, rst_n, st_r == B_DONE && (!ov_r || out_ready),
                  ov_r && st_r == B_IDLE)
endmodule
`default_nettype wire

FILE: bench/base10000_numeric_to_scaled_int128_tb.sv
// testbench of the base-10000 decimal to scaled 128-bit integer converter
// needs bnc_pkg, the channel interfaces in bnc_ifs.sv and the converter itself
`timescale 1ns / 1ps
`default_nettype none
module base10000_numeric_to_scaled_int128_tb;
  import bnc_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  // longest back-end pass: 38 divisor steps plus the 128-step divider, with margin
  localparam int unsigned SettleCycles = 400;

  logic clk;
  logic rst_n;

  bnc_in_if  in_ch ();
  bnc_out_if out_ch ();
  bnc_cfg_if cfg_ch ();

  base10000_numeric_to_scaled_int128 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state, a private copy of what the converter tracks per number
  logic [5:0]   scale_q;
  logic [1:0]   phase_q;
  logic         neg_q;
  logic         special_q;
  logic [15:0]  weight_q;
  logic [7:0]   ndig_q;
  logic [127:0] acc_q;

  logic [127:0] scaled_q[$];   // expected scaled values, oldest first
  int unsigned  errors;
  int unsigned  cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_number();
    phase_q   = PhHeader;
    neg_q     = 1'b0;
    special_q = 1'b0;
    weight_q  = '0;
    ndig_q    = '0;
    acc_q     = '0;
  endfunction

  // value * 10^scale from the collected digits, wrapping mod 2^128
  function automatic logic [127:0] scaled_value();
    int           wt;
    int           ex;
    int           k;
    logic [127:0] v;
    logic [127:0] den;
    logic         vneg;
    if (special_q || ndig_q == 0) return '0;
    v  = acc_q;
    wt = $signed(weight_q);
    ex = 4 * (wt - int'(ndig_q) + 1) + int'(scale_q);
    if (ex >= 128) return '0;
    if (ex >= 0) begin
      repeat (ex) v = v * 128'd10;
    end else begin
      k = -ex;
      if (k > MaxDivPow) return '0;
      den = 128'd1;
      repeat (k) den = den * 128'd10;
      vneg = v[127];
      if (vneg) v = -v;
      v = v / den;
      if (vneg) v = -v;
    end
    if (neg_q) v = -v;
    return v;
  endfunction

  // advance the predictor by one accepted word
  function automatic void absorb_word(logic [15:0] w, logic lst);
    if (phase_q == PhWeight) begin
      weight_q = w;
      phase_q  = PhDigits;
    end else if (phase_q == PhDigits) begin
      if (!special_q && ndig_q < MaxDigits) begin
        acc_q  = acc_q * 128'd10000 + {{112{w[15]}}, w};
        ndig_q = ndig_q + 1'b1;
      end
    end else begin
      clear_number();
      if (w[15:14] == HdrSpecial) begin
        special_q = 1'b1;
        phase_q   = PhDigits;
      end else if (w[15:14] == HdrShort) begin
        neg_q    = w[13];
        weight_q = w[6] ? {10'h3FF, w[5:0]} : {10'h000, w[5:0]};
        phase_q  = PhDigits;
      end else begin
        neg_q   = (w[15:14] == HdrLongNeg);
        phase_q = PhWeight;
      end
    end
    if (lst) begin
      scaled_q.push_back(scaled_value());
      clear_number();
    end
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one item over the input channel, predictor updated on acceptance
  task automatic send_item(logic [15:0] w, logic lst);
    repeat (gap_len()) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.word  = w;
    in_ch.last  = lst;
    do @(posedge clk); while (!in_ch.ready);
    absorb_word(w, lst);
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.word  = 16'($urandom);
    in_ch.last  = 1'($urandom);
  endtask

  task automatic send_number(logic [15:0] words[$]);
    foreach (words[i]) send_item(words[i], i == words.size() - 1);
  endtask

  // wait for every pending result, then let the back end go quiet
  task automatic drain();
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_scale(logic [5:0] s);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.scale = s;
    do @(posedge clk); while (!cfg_ch.ready);
    scale_q = s;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // result side: random stalls on ready, compare at the rising edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      case ($urandom_range(9))
        0: begin
          out_ch.ready = 1'b0;
          repeat ($urandom_range(30, 5)) @(negedge clk);
        end
        1, 2: out_ch.ready = 1'b0;
        default: out_ch.ready = 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (scaled_q.size() == 0) begin
        $error("unexpected result value_high=%0h value_low=%0h",
               out_ch.value_high, out_ch.value_low);
        errors++;
      end else begin
        want = scaled_q.pop_front();
        if (out_ch.value_low !== want[63:0]) begin
          $error("value_low expected %0h got %0h", want[63:0], out_ch.value_low);
          errors++;
        end
        if (out_ch.value_high !== want[127:64]) begin
          $error("value_high expected %0h got %0h", want[127:64], out_ch.value_high);
          errors++;
        end
      end
    end
  end

  function automatic logic [15:0] short_hdr(logic sgn, int wt);
    logic [6:0] w7;
    w7 = wt[6:0];
    return {HdrShort, sgn, 6'($urandom), w7};
  endfunction

  function automatic logic [15:0] long_hdr(logic sgn);
    return {sgn ? HdrLongNeg : HdrLongPos, 14'($urandom)};
  endfunction

  // short forms, both signs, weight sign and magnitude extremes
  task automatic test_short_forms();
    send_number('{short_hdr(1'b0, 0), 16'd1234, 16'd5678});
    send_number('{short_hdr(1'b1, 1), 16'd9999, 16'd9999, 16'd9999});
    send_number('{short_hdr(1'b0, -1), 16'd42});
    send_number('{short_hdr(1'b1, 63), 16'd1});
    send_number('{short_hdr(1'b0, -64), 16'd7});
    send_number('{short_hdr(1'b1, -3), 16'd0, 16'd5000});
  endtask

  // long forms with weight extremes
  task automatic test_long_forms();
    send_number('{long_hdr(1'b0), 16'h0000, 16'd31, 16'd4159});
    send_number('{long_hdr(1'b1), 16'hFFFF, 16'd2718});
    send_number('{long_hdr(1'b0), 16'h7FFF, 16'd1});
    send_number('{long_hdr(1'b1), 16'h8000, 16'd1});
    send_number('{long_hdr(1'b0), 16'd2, 16'd12, 16'd3456});
  endtask

  // special values and numbers that end before any digit
  task automatic test_specials_and_empty();
    send_number('{{HdrSpecial, 14'h0000}, 16'd1234, 16'd1});
    send_number('{{HdrSpecial, 14'h3FFF}});
    send_number('{short_hdr(1'b1, 5)});
    send_number('{long_hdr(1'b0)});
    send_number('{long_hdr(1'b1), 16'd3});
  endtask

  // digit words above 9999 and with the top bit set are used unchecked
  task automatic test_digit_extremes();
    send_number('{short_hdr(1'b0, 0), 16'hFFFF});
    send_number('{short_hdr(1'b1, 2), 16'h8000, 16'd10000});
    send_number('{short_hdr(1'b0, 1), 16'h7FFF, 16'hFFFF});
  endtask

  // more digits than the converter keeps
  task automatic test_excess_digits();
    logic [15:0] ws[$];
    ws.push_back(short_hdr(1'b0, -100));
    repeat (MaxDigits + 6) ws.push_back(16'($urandom_range(9999)));
    send_number(ws);
  endtask

  // multiplier power of 128 or more, divisor just inside and beyond 10^38
  task automatic test_scaling_extremes();
    send_number('{long_hdr(1'b0), 16'd40, 16'd9});
    send_number('{long_hdr(1'b1), 16'd16, 16'd9999, 16'd1});
    send_number('{long_hdr(1'b0), -16'sd10, 16'd9999});
    send_number('{long_hdr(1'b1), -16'sd9, 16'd9999});
    send_number('{short_hdr(1'b1, 7), 16'h8001, 16'd3});
  endtask

  // mostly well-formed numbers with random content, some noise and broken ones
  task automatic test_random_numbers(int unsigned n_items);
    int unsigned sent;
    int unsigned nd;
    int unsigned r;
    logic [15:0] ws[$];
    logic        lst;
    logic        held;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        ws.delete();
        case ($urandom_range(9))
          0: ws.push_back({HdrSpecial, 14'($urandom)});
          1, 2, 3, 4: ws.push_back(short_hdr(1'($urandom), $urandom_range(12) - 6));
          default: begin
            ws.push_back(long_hdr(1'($urandom)));
            ws.push_back($urandom_range(19) < 17 ? 16'($urandom_range(16) - 8)
                                                  : 16'($urandom));
          end
        endcase
        nd = ($urandom_range(49) == 0) ? $urandom_range(140, 20) : $urandom_range(8);
        repeat (nd) ws.push_back($urandom_range(9) == 0 ? 16'($urandom)
                                                         : 16'($urandom_range(9999)));
        send_number(ws);
        sent += ws.size();
      end else begin
        lst = ($urandom_range(3) == 0);
        send_item(16'($urandom), lst);
        sent++;
      end
      // hold the sender once until every pending result is out
      if (!held && sent > n_items / 2) begin
        drain();
        held = 1'b1;
      end
    end
    send_item(short_hdr(1'($urandom), 0), 1'b1);
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.word   = '0;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.scale = '0;
    scale_q      = 6'd2;
    clear_number();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset scale first
    test_short_forms();
    test_long_forms();
    test_specials_and_empty();
    test_digit_extremes();
    test_excess_digits();
    test_scaling_extremes();
    test_random_numbers(200);

    set_scale(6'd0);
    test_short_forms();
    test_scaling_extremes();
    test_random_numbers(250);

    set_scale(6'd38);
    test_long_forms();
    test_scaling_extremes();
    test_random_numbers(250);

    set_scale(6'd63);
    test_digit_extremes();
    test_random_numbers(200);

    set_scale(6'($urandom_range(37, 1)));
    test_random_numbers(250);

    set_scale(6'd2);
    test_random_numbers(180);

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
